>>> hw/rtl/sbbp_pkg.sv
package sbbp_pkg;

  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
  } out_beat_t;

  typedef struct packed {
    logic       head_vld;
    logic [7:0] head_byte;
    logic [2:0] flush_cnt;
    logic [7:0] flush_byte;
    logic       eos;
  } job_t;

endpackage

>>> hw/rtl/seven_bit_byte_packer.sv
// Seven-bit byte packer.
// Input channel (in_valid / in_stall / in_data): one byte per beat; bit 0 of
// each byte is dropped and the upper seven bits are joined MSB first, so
// eight input beats give seven output beats. end_of_stream on a beat pads
// the open group with zero bytes and flushes it.
// Output channel (out_valid / out_stall / out_data): one packed byte per
// beat; final_byte marks the last byte of a flush.
// A result byte passes through the job queue and the output register
// before it is offered on out_valid.
// Throughput: one input beat per cycle while in_stall is low. A flush beat
// yields up to seven output beats, sent one per cycle by the output stage
// while out_stall is low; a four-entry job queue lets input keep flowing
// meanwhile until it fills, then in_stall rises.
// Stall: out_stall holds the output register; the queue fills and then
// in_stall backs up the input. in_stall depends only on queue occupancy.
// Reset (rst_n low, synchronous) clears the bit accumulator, group position,
// queue and output valid; the next beat starts a new stream.
module seven_bit_byte_packer
  import sbbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_vld;
  job_t head_job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  sbbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push),
    .job     (push_job)
  );

  sbbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  sbbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (head_vld),
    .job       (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/sbbp_front.sv
module sbbp_front
  import sbbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_beat_t in_data,
  output logic     push,
  output job_t     job
);

  logic [2:0]  pos_r;
  logic [2:0]  pos_nxt;
  logic [6:0]  left_r;
  logic [6:0]  left_nxt;
  logic [6:0]  d;
  logic [13:0] acc;
  logic [6:0]  new_left;
  logic [2:0]  npos;
  logic [2:0]  rem;

  always_comb begin
    d        = in_data.data_byte[7:1];
    acc      = {left_r, d};
    rem      = 3'd7 - pos_r;
    new_left = d & (7'h7F >> pos_r);
    npos     = pos_r + 3'd1;

    job.head_vld   = (pos_r != 3'd0);
    job.head_byte  = 8'(acc >> rem);
    job.flush_cnt  = (in_data.end_of_stream && npos != 3'd0) ? rem : 3'd0;
    job.flush_byte = {1'b0, new_left} << npos;
    job.eos        = in_data.end_of_stream;

    push = accept && ((pos_r != 3'd0) || in_data.end_of_stream);

    pos_nxt  = pos_r;
    left_nxt = left_r;
    if (accept) begin
      if (in_data.end_of_stream) begin
        pos_nxt  = 3'd0;
        left_nxt = 7'd0;
      end else begin
        pos_nxt  = npos;
        left_nxt = new_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      left_r <= 7'd0;
    end else begin
      pos_r  <= pos_nxt;
      left_r <= left_nxt;
    end
  end

`ifndef SYNTHESIS
  a_group_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == 3'd0 |-> left_r == 7'd0)
    else $error("leftover bits held at group start");
`endif

endmodule

>>> hw/rtl/sbbp_queue.sv
module sbbp_queue
  import sbbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_vld,
  output job_t head_job
);

  job_t             mem_r [QDepth];
  logic [QIdxW-1:0] wr_ptr_r;
  logic [QIdxW-1:0] rd_ptr_r;
  logic [QCntW-1:0] cnt_r;
  logic [QCntW-1:0] cnt_nxt;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/sbbp_back.sv
module sbbp_back
  import sbbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_vld,
  input  job_t      job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  out_beat_t  out_r;
  out_beat_t  out_nxt;
  logic       load;
  logic       last;
  logic [3:0] total;
  logic [7:0] beat_byte;

  always_comb begin
    total = {1'b0, job.flush_cnt} + {3'd0, job.head_vld};
    last  = ({1'b0, cnt_r} == total - 4'd1);
    if (job.head_vld && cnt_r == 3'd0) begin
      beat_byte = job.head_byte;
    end else if (cnt_r == {2'd0, job.head_vld}) begin
      beat_byte = job.flush_byte;
    end else begin
      beat_byte = 8'h00;
    end

    load = job_vld && (!out_vld_r || !out_stall);
    pop  = load && last;

    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (load) begin
      out_vld_nxt         = 1'b1;
      out_nxt.packed_byte = beat_byte;
      out_nxt.final_byte  = job.eos && last;
      cnt_nxt             = last ? 3'd0 : cnt_r + 3'd1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> cnt_r == 3'd0)
    else $error("beat count not cleared after job");
  a_final_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    load && !last |=> !out_r.final_byte)
    else $error("final beat inside a job");
`endif

endmodule
